// ===== src/display_window_pixel_streamer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the display window pixel streamer
// Shared property forms with an asynchronous active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef DISPLAY_WINDOW_PIXEL_STREAMER_MACROS_SVH
`define DISPLAY_WINDOW_PIXEL_STREAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define DWPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DWPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dwps_pkg.sv =====
// ---------------------------------------------------------------------------
// Display window pixel streamer package
// Panel geometry, controller commands, status codes and the job descriptor
// passed from the front end to the byte sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package dwps_pkg;

    // Panel geometry
    localparam logic [8:0] PANEL_WIDTH  = 9'd240;
    localparam logic [8:0] PANEL_HEIGHT = 9'd240;

    // Chunk size saturation bounds
    localparam logic [15:0] CHUNK_MIN   = 16'(PANEL_WIDTH);
    localparam logic [15:0] CHUNK_MAX   = 16'd32768;
    localparam logic [15:0] CHUNK_RESET = 16'd2048;

    // Controller commands
    localparam logic [7:0] CMD_COLUMN_SET     = 8'h2A;
    localparam logic [7:0] CMD_ROW_SET        = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE      = 8'h2C;
    localparam logic [7:0] CMD_MEM_WRITE_MORE = 8'h3C;

    // Input actions
    localparam logic [1:0] ACT_FILL   = 2'd0;
    localparam logic [1:0] ACT_BITMAP = 2'd1;
    localparam logic [1:0] ACT_PIXEL  = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REJECT   = 2'd1;
    localparam logic [1:0] STAT_NO_WINDOW = 2'd2;

    // Byte positions of the last byte of each job kind
    localparam logic [3:0] WIN_LAST_IDX = 4'd9;
    localparam logic [3:0] PIX_LAST_IDX = 4'd2;
    localparam logic [3:0] ERR_LAST_IDX = 4'd0;

    // Job queue geometry
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_DEPTH = 1 << FIFO_PTR_W;
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef enum logic [1:0] {
        JOB_ERROR  = 2'd0,
        JOB_WINDOW = 2'd1,
        JOB_PIXEL  = 2'd2
    } dwps_kind_t;

    // One queued job: everything the sequencer needs to emit its bytes
    typedef struct packed {
        dwps_kind_t  kind;
        logic [1:0]  status;
        logic [7:0]  xs;
        logic [7:0]  xe;
        logic [7:0]  ys;
        logic [7:0]  ye;
        logic [15:0] px;
        logic        has_cmd;
        logic        cmd_more;
        logic        done;
    } dwps_job_t;

    // Queue write strobe from the front end
    typedef struct packed {
        logic push;
    } dwps_qwr_t;

endpackage

`default_nettype wire

// ===== src/dwps_channels.sv =====
// ---------------------------------------------------------------------------
// Display window pixel streamer channels
// Valid/ready request channel and byte result channel.
// ---------------------------------------------------------------------------
`default_nettype none

interface dwps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  rect_width;
    logic [7:0]  rect_height;
    logic [15:0] fill_color;
    logic [15:0] pixel_value;

    modport source (
        output valid, action, x_start, y_start, rect_width, rect_height,
               fill_color, pixel_value,
        input  ready
    );
    modport sink (
        input  valid, action, x_start, y_start, rect_width, rect_height,
               fill_color, pixel_value,
        output ready
    );
endinterface

interface dwps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic [1:0] status;
    logic       rect_done;
    logic       last;

    modport source (
        output valid, out_byte, is_data, status, rect_done, last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, is_data, status, rect_done, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/display_window_pixel_streamer.sv =====
// ---------------------------------------------------------------------------
// Display window pixel streamer
// Turns rectangle draw requests into a command/data tagged byte stream for a
// serial RGB565 display controller.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries requests (fill start, bitmap start, pixel); a transfer
//   happens when valid and ready are both high. out_ch carries one byte per
//   transfer with its command/data flag, status, rect_done and last.
//   cfg_we/cfg_data write the chunk size; write it only while idle.
// Path: a request is written into the job queue, and its first byte is then
//   loaded into the output register. The output runs at one byte per cycle
//   while out_ch.ready stays high: a start gives ten bytes, a pixel two, or
//   three when it opens a chunk; an error gives one.
// Throughput is set by the single output byte register; requests queue in
//   a four-entry job queue and are accepted while it has room, so a new
//   request is taken while earlier bytes are still being sent.
// Reset: window closed, chunk size 2048, queue and output empty.
// Stall: when out_ch.ready is low the current byte holds; once the queue
//   fills, in_ch.ready drops until bytes drain.
// ---------------------------------------------------------------------------
`default_nettype none

module display_window_pixel_streamer import dwps_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    dwps_in_if.sink          in_ch,
    dwps_out_if.source       out_ch
);

    dwps_qwr_t q_wr;
    dwps_job_t wr_job;
    dwps_job_t rd_job;
    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;

    // request classification and window state
    dwps_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .q_wr     (q_wr),
        .q_full   (q_full),
        .q_job    (wr_job)
    );

    // job queue
    dwps_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .wr_job    (wr_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_job    (rd_job)
    );

    // byte sequencer
    dwps_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_job       (rd_job),
        .q_pop       (q_pop),
        .out_ch      (out_ch)
    );

endmodule

`default_nettype wire

// ===== src/dwps_fifo.sv =====
// ---------------------------------------------------------------------------
// Job queue
// Small register queue that decouples the front end from the sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "display_window_pixel_streamer_macros.svh"

module dwps_fifo import dwps_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dwps_qwr_t wr,
    input  wire dwps_job_t wr_job,
    output logic           full,
    input  wire logic      pop,
    output logic           not_empty,
    output dwps_job_t      rd_job
);

    dwps_job_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_job    = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (wr.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !wr.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `DWPS_ASSERT_SAME(a_push_room, clk, rst_n, wr.push, !full, "push into full job queue")
    `DWPS_ASSERT_SAME(a_pop_data, clk, rst_n, pop, not_empty, "pop from empty job queue")
    `DWPS_ASSERT_NEXT(a_count_up, clk, rst_n, wr.push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

// ===== src/dwps_front.sv =====
// ---------------------------------------------------------------------------
// Front end
// Accepts requests, checks rectangles, tracks window and chunk state and
// queues one job per request that produces bytes.
// ---------------------------------------------------------------------------
`default_nettype none

module dwps_front import dwps_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    dwps_in_if.sink          in_ch,
    output dwps_qwr_t        q_wr,
    input  wire logic        q_full,
    output dwps_job_t        q_job
);

    logic [15:0] chunk_pixels_reg;
    logic        window_open_reg,  window_open_next;
    logic        fill_mode_reg,    fill_mode_next;
    logic [15:0] held_color_reg,   held_color_next;
    logic [15:0] pixels_rem_reg,   pixels_rem_next;
    logic [14:0] chunk_pos_reg,    chunk_pos_next;
    logic        first_chunk_reg,  first_chunk_next;

    logic        accept;
    logic        is_start;
    logic        rect_bad;
    logic [8:0]  x_end_sum;
    logic [8:0]  y_end_sum;
    logic [15:0] chunk_lim;
    logic [15:0] pos_inc;
    logic [15:0] area;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign is_start    = (in_ch.action == ACT_FILL) || (in_ch.action == ACT_BITMAP);

    // bounds check
    assign x_end_sum = {1'b0, in_ch.x_start} + {1'b0, in_ch.rect_width};
    assign y_end_sum = {1'b0, in_ch.y_start} + {1'b0, in_ch.rect_height};
    assign rect_bad  = (in_ch.rect_width == '0) || (in_ch.rect_height == '0) ||
                       (x_end_sum > PANEL_WIDTH) || (y_end_sum > PANEL_HEIGHT);
    assign area      = 16'(in_ch.rect_width) * 16'(in_ch.rect_height);

    // chunk size saturated to its legal range
    always_comb
    begin
        if (chunk_pixels_reg < CHUNK_MIN)
        begin
            chunk_lim = CHUNK_MIN;
        end
        else if (chunk_pixels_reg > CHUNK_MAX)
        begin
            chunk_lim = CHUNK_MAX;
        end
        else
        begin
            chunk_lim = chunk_pixels_reg;
        end
    end

    assign pos_inc = {1'b0, chunk_pos_reg} + 16'd1;

    // classify the request and update window state
    always_comb
    begin
        window_open_next = window_open_reg;
        fill_mode_next   = fill_mode_reg;
        held_color_next  = held_color_reg;
        pixels_rem_next  = pixels_rem_reg;
        chunk_pos_next   = chunk_pos_reg;
        first_chunk_next = first_chunk_reg;
        q_wr.push        = 1'b0;
        q_job            = '0;
        q_job.kind       = JOB_ERROR;
        q_job.status     = STAT_OK;

        if (accept && is_start)
        begin
            q_wr.push = 1'b1;
            if (rect_bad)
            begin
                q_job.status = STAT_REJECT;
            end
            else
            begin
                q_job.kind       = JOB_WINDOW;
                q_job.xs         = in_ch.x_start;
                q_job.xe         = x_end_sum[7:0] - 8'd1;
                q_job.ys         = in_ch.y_start;
                q_job.ye         = y_end_sum[7:0] - 8'd1;
                window_open_next = 1'b1;
                fill_mode_next   = (in_ch.action == ACT_FILL);
                held_color_next  = in_ch.fill_color;
                pixels_rem_next  = area;
                chunk_pos_next   = '0;
                first_chunk_next = 1'b1;
            end
        end
        else if (accept && (in_ch.action == ACT_PIXEL))
        begin
            q_wr.push = 1'b1;
            if (!window_open_reg)
            begin
                q_job.status = STAT_NO_WINDOW;
            end
            else
            begin
                q_job.kind     = JOB_PIXEL;
                q_job.px       = fill_mode_reg ? held_color_reg : in_ch.pixel_value;
                q_job.has_cmd  = (chunk_pos_reg == '0);
                q_job.cmd_more = !first_chunk_reg;
                pixels_rem_next = pixels_rem_reg - 16'd1;
                q_job.done      = (pixels_rem_next == '0);
                if (pos_inc >= chunk_lim)
                begin
                    chunk_pos_next   = '0;
                    first_chunk_next = 1'b0;
                end
                else
                begin
                    chunk_pos_next = pos_inc[14:0];
                end
                if (q_job.done)
                begin
                    window_open_next = 1'b0;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_pixels_reg <= CHUNK_RESET;
            window_open_reg  <= 1'b0;
            fill_mode_reg    <= 1'b0;
            held_color_reg   <= '0;
            pixels_rem_reg   <= '0;
            chunk_pos_reg    <= '0;
            first_chunk_reg  <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                chunk_pixels_reg <= cfg_data;
            end
            window_open_reg <= window_open_next;
            fill_mode_reg   <= fill_mode_next;
            held_color_reg  <= held_color_next;
            pixels_rem_reg  <= pixels_rem_next;
            chunk_pos_reg   <= chunk_pos_next;
            first_chunk_reg <= first_chunk_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/dwps_back.sv =====
// ---------------------------------------------------------------------------
// Byte sequencer
// Expands the job at the queue head into controller bytes, one per cycle
// unless out_ch.ready holds the output, into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "display_window_pixel_streamer_macros.svh"

module dwps_back import dwps_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_not_empty,
    input  wire dwps_job_t q_job,
    output logic           q_pop,
    dwps_out_if.source     out_ch
);

    logic [3:0] cnt_reg;
    logic [3:0] idx;
    logic [3:0] last_idx;
    logic       load;
    logic       is_last;

    logic       valid_reg;
    logic [7:0] byte_reg,   byte_next;
    logic       data_reg,   data_next;
    logic [1:0] status_reg;
    logic       done_reg,   done_next;
    logic       last_reg;

    assign load  = q_not_empty && (!valid_reg || out_ch.ready);
    // a pixel job without a chunk command starts at its high byte
    assign idx   = cnt_reg + {3'b000, (q_job.kind == JOB_PIXEL) && !q_job.has_cmd};

    always_comb
    begin
        unique case (q_job.kind)
            JOB_WINDOW: last_idx = WIN_LAST_IDX;
            JOB_PIXEL:  last_idx = PIX_LAST_IDX;
            default:    last_idx = ERR_LAST_IDX;
        endcase
    end

    assign is_last = (idx == last_idx);
    assign q_pop   = load && is_last;

    // byte selection; window high bytes are zero as coordinates fit in 8 bits
    always_comb
    begin
        byte_next = 8'h00;
        data_next = 1'b1;
        done_next = 1'b0;
        unique case (q_job.kind)
            JOB_WINDOW:
            begin
                case (idx)
                    4'd0:
                    begin
                        byte_next = CMD_COLUMN_SET;
                        data_next = 1'b0;
                    end
                    4'd2:    byte_next = q_job.xs;
                    4'd4:    byte_next = q_job.xe;
                    4'd5:
                    begin
                        byte_next = CMD_ROW_SET;
                        data_next = 1'b0;
                    end
                    4'd7:    byte_next = q_job.ys;
                    4'd9:    byte_next = q_job.ye;
                    default: byte_next = 8'h00;
                endcase
            end
            JOB_PIXEL:
            begin
                case (idx)
                    4'd0:
                    begin
                        byte_next = q_job.cmd_more ? CMD_MEM_WRITE_MORE : CMD_MEM_WRITE;
                        data_next = 1'b0;
                    end
                    4'd1:    byte_next = q_job.px[15:8];
                    default:
                    begin
                        byte_next = q_job.px[7:0];
                        done_next = q_job.done;
                    end
                endcase
            end
            default:
            begin
                data_next = 1'b0;
            end
        endcase
    end

    // byte counter and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                cnt_reg   <= is_last ? 4'd0 : cnt_reg + 4'd1;
                valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            data_reg   <= data_next;
            status_reg <= q_job.status;
            done_reg   <= done_next;
            last_reg   <= is_last;
        end
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.out_byte  = byte_reg;
    assign out_ch.is_data   = data_reg;
    assign out_ch.status    = status_reg;
    assign out_ch.rect_done = done_reg;
    assign out_ch.last      = last_reg;

    `DWPS_ASSERT_SAME(a_pop_on_load, clk, rst_n, q_pop, load && q_not_empty, "job popped without a transfer slot")
    `DWPS_ASSERT_SAME(a_err_single, clk, rst_n, valid_reg && (status_reg != STAT_OK), last_reg && !done_reg && !data_reg, "error result not a lone command-flagged byte")
    `DWPS_ASSERT_SAME(a_done_last, clk, rst_n, valid_reg && done_reg, last_reg && data_reg, "rect_done away from final pixel byte")

endmodule

`default_nettype wire
